// File: hdl/apu_frame_and_length_unit_assert.svh
// Assertion macros shared by the frame and length unit.
// Each macro expects clk and rst_n in scope.
`ifndef APU_FRAME_AND_LENGTH_UNIT_ASSERT_SVH
`define APU_FRAME_AND_LENGTH_UNIT_ASSERT_SVH

// Same-cycle implication.
`define APU_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication that checks the following cycle.
`define APU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/apu_fal_pkg.sv
package apu_fal_pkg;

    // Event kinds carried with each item
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;
    localparam logic [1:0] KIND_SAMPLE = 2'd3;

    // Register offsets that the unit decodes
    localparam logic [4:0] REG_STATUS = 5'h15;
    localparam logic [4:0] REG_FRAME  = 5'h17;

    // Frame sequencer step points
    localparam logic [15:0] STEP_Q1      = 16'd7457;
    localparam logic [15:0] STEP_Q2      = 16'd14913;
    localparam logic [15:0] STEP_Q3      = 16'd22371;
    localparam logic [15:0] STEP4_IRQ    = 16'd29828;
    localparam logic [15:0] STEP4_HALF   = 16'd29829;
    localparam logic [15:0] STEP4_END    = 16'd29830;
    localparam logic [15:0] STEP5_HALF   = 16'd37281;
    localparam logic [15:0] STEP5_END    = 16'd37282;

    // Restart delay loaded by a frame register write
    localparam logic [7:0] DELAY_IDLE = 8'hFF;
    localparam logic [7:0] DELAY_PUT  = 8'd3;
    localparam logic [7:0] DELAY_GET  = 8'd4;
    localparam logic [7:0] DELAY_MAX  = 8'd4;

    localparam int NUM_CH = 4;

    // Length load table, indexed by write_data[7:3]
    localparam logic [7:0] LEN_TABLE [0:31] = '{
        8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
        8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
        8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
        8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
    };

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] reg_addr;
        logic [7:0] write_data;
        logic       open_bus_bit5;
        logic       cart_irq;
    } apu_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_out;
        logic       quarter_clock;
        logic       half_clock;
    } apu_result_t;

    // Sequencer to length counters: clocking for this transfer
    typedef struct packed {
        logic tick;
        logic half;
    } seq_len_t;

    // Sequencer outputs for the result
    typedef struct packed {
        logic irq_out;
        logic quarter_clock;
        logic half_clock;
        logic irq_flag;
    } seq_res_t;

endpackage

// File: hdl/apu_fal_seq.sv
module apu_fal_seq
    import apu_fal_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  apu_item_t item,
    output seq_len_t  to_len,
    output seq_res_t  res
);

    logic        put_reg, put_next;
    logic        five_reg, five_next;
    logic        inh_reg, inh_next;
    logic [7:0]  delay_reg, delay_next;
    logic [15:0] fc_reg, fc_next;
    logic        pq_reg, pq_next;
    logic        ph_reg, ph_next;
    logic        flag_reg, flag_next;
    logic        clr_reg, clr_next;
    logic        line_reg, line_next;
    logic        q_fire, h_fire;
    logic        tick_taken;
    logic        inhibit_wr;

    // Work out the sequencer state after this item
    always_comb
    begin
        put_next   = put_reg;
        five_next  = five_reg;
        inh_next   = inh_reg;
        delay_next = delay_reg;
        fc_next    = fc_reg;
        pq_next    = pq_reg;
        ph_next    = ph_reg;
        flag_next  = flag_reg;
        clr_next   = clr_reg;
        line_next  = line_reg;
        q_fire     = 1'b0;
        h_fire     = 1'b0;
        case (item.kind)
            KIND_TICK:
            begin
                // drop the frame interrupt on the put half after a status read
                if (put_reg && clr_reg)
                begin
                    clr_next  = 1'b0;
                    flag_next = 1'b0;
                    line_next = 1'b0;
                end
                // count down a pending restart
                if (!delay_reg[7])
                begin
                    delay_next = delay_reg - 8'd1;
                    if (delay_next[7])
                        fc_next = '0;
                end
                fc_next = fc_next + 16'd1;
                if (fc_next == STEP_Q1 || fc_next == STEP_Q3)
                    pq_next = 1'b1;
                else if (fc_next == STEP_Q2)
                begin
                    pq_next = 1'b1;
                    ph_next = 1'b1;
                end
                else if (five_reg)
                begin
                    if (fc_next == STEP5_HALF)
                    begin
                        pq_next = 1'b1;
                        ph_next = 1'b1;
                    end
                    else if (fc_next == STEP5_END)
                        fc_next = '0;
                end
                else if (fc_next == STEP4_IRQ)
                    flag_next = 1'b1;
                else if (fc_next == STEP4_HALF)
                begin
                    pq_next   = 1'b1;
                    ph_next   = 1'b1;
                    flag_next = 1'b1;
                    if (!inh_reg)
                        line_next = 1'b1;
                end
                else if (fc_next == STEP4_END)
                begin
                    flag_next = !inh_reg;
                    if (!inh_reg)
                        line_next = 1'b1;
                    fc_next = '0;
                end
                q_fire   = pq_next;
                h_fire   = ph_next;
                pq_next  = 1'b0;
                ph_next  = 1'b0;
                put_next = !put_reg;
            end
            KIND_WRITE:
            begin
                if (item.reg_addr == REG_FRAME)
                begin
                    five_next = item.write_data[7];
                    inh_next  = item.write_data[6];
                    if (item.write_data[7])
                    begin
                        pq_next = 1'b1;
                        ph_next = 1'b1;
                    end
                    if (item.write_data[6])
                    begin
                        flag_next = 1'b0;
                        line_next = 1'b0;
                    end
                    delay_next = put_reg ? DELAY_PUT : DELAY_GET;
                end
            end
            KIND_READ:
                clr_next = 1'b1;
            default:
            begin
                if (flag_reg && !inh_reg)
                    line_next = 1'b1;
            end
        endcase
    end

    // Result fields and clocking for the length counters
    always_comb
    begin
        to_len.tick       = (item.kind == KIND_TICK);
        to_len.half       = h_fire;
        res.quarter_clock = q_fire;
        res.half_clock    = h_fire;
        res.irq_flag      = flag_reg;
        if (item.kind == KIND_SAMPLE)
            res.irq_out = line_reg | item.cart_irq;
        else
            res.irq_out = line_next | item.cart_irq;
    end

    // Hold state; advance on each transfer into the result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            put_reg   <= 1'b1;
            five_reg  <= 1'b0;
            inh_reg   <= 1'b0;
            delay_reg <= DELAY_IDLE;
            fc_reg    <= '0;
            pq_reg    <= 1'b0;
            ph_reg    <= 1'b0;
            flag_reg  <= 1'b0;
            clr_reg   <= 1'b0;
            line_reg  <= 1'b0;
        end
        else if (en)
        begin
            put_reg   <= put_next;
            five_reg  <= five_next;
            inh_reg   <= inh_next;
            delay_reg <= delay_next;
            fc_reg    <= fc_next;
            pq_reg    <= pq_next;
            ph_reg    <= ph_next;
            flag_reg  <= flag_next;
            clr_reg   <= clr_next;
            line_reg  <= line_next;
        end
    end

    // Transfers that the checks below key on
    assign tick_taken = en && item.kind == KIND_TICK;
    assign inhibit_wr = en && item.kind == KIND_WRITE && item.reg_addr == REG_FRAME
                        && item.write_data[6];

`include "apu_frame_and_length_unit_assert.svh"

    `APU_ASSERT_IMPLIES(a_delay_range, !delay_reg[7], delay_reg <= DELAY_MAX, "restart delay too large")
    `APU_ASSERT_NEXT(a_put_toggles, tick_taken, put_reg != $past(put_reg), "phase did not toggle")
    `APU_ASSERT_NEXT(a_inhibit_clears, inhibit_wr, !line_reg && !flag_reg, "inhibit left irq set")

endmodule

// File: hdl/apu_fal_len.sv
module apu_fal_len
    import apu_fal_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  apu_item_t         item,
    input  seq_len_t          from_seq,
    output logic [NUM_CH-1:0] nonzero
);

    logic [7:0]        cnt_reg  [NUM_CH];
    logic [7:0]        cnt_next [NUM_CH];
    logic [7:0]        rv_reg   [NUM_CH];
    logic [7:0]        rv_next  [NUM_CH];
    logic [NUM_CH-1:0] rp_reg, rp_next;
    logic [NUM_CH-1:0] halt_reg, halt_next;
    logic [NUM_CH-1:0] src_reg, src_next;
    logic [NUM_CH-1:0] en_reg, en_next;

    // Update each channel's counter for this item
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            cnt_next[c]  = cnt_reg[c];
            rv_next[c]   = rv_reg[c];
            rp_next[c]   = rp_reg[c];
            halt_next[c] = halt_reg[c];
            src_next[c]  = src_reg[c];
            en_next[c]   = en_reg[c];
            if (from_seq.tick)
            begin
                if (from_seq.half)
                begin
                    // reload only takes on an empty counter
                    if (rp_reg[c] && cnt_reg[c] == 8'd0)
                        cnt_next[c] = rv_reg[c];
                    else
                        rp_next[c] = 1'b0;
                    if (!en_reg[c])
                        cnt_next[c] = 8'd0;
                    if (cnt_next[c] != 8'd0 && !halt_reg[c] && !rp_next[c])
                        cnt_next[c] = cnt_next[c] - 8'd1;
                end
                else
                begin
                    if (rp_reg[c])
                        cnt_next[c] = rv_reg[c];
                    rp_next[c] = 1'b0;
                end
                halt_next[c] = src_reg[c];
            end
            else if (item.kind == KIND_WRITE)
            begin
                if (item.reg_addr == 5'(4 * c))
                    src_next[c] = (c == 2) ? item.write_data[7] : item.write_data[5];
                if (item.reg_addr == 5'(4 * c + 3) && en_reg[c])
                begin
                    rv_next[c] = LEN_TABLE[item.write_data[7:3]];
                    rp_next[c] = 1'b1;
                end
                if (item.reg_addr == REG_STATUS)
                begin
                    en_next[c] = item.write_data[c];
                    if (!item.write_data[c])
                        cnt_next[c] = 8'd0;
                end
            end
            nonzero[c] = (cnt_reg[c] != 8'd0);
        end
    end

    // Hold counters; advance on each transfer into the result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                cnt_reg[c] <= 8'd0;
                rv_reg[c]  <= 8'd0;
            end
            rp_reg   <= '0;
            halt_reg <= '0;
            src_reg  <= '0;
            en_reg   <= '0;
        end
        else if (en)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                cnt_reg[c] <= cnt_next[c];
                rv_reg[c]  <= rv_next[c];
            end
            rp_reg   <= rp_next;
            halt_reg <= halt_next;
            src_reg  <= src_next;
            en_reg   <= en_next;
        end
    end

endmodule

// File: hdl/apu_frame_and_length_unit.sv
// Frame sequencer and four length counters of the sound unit.
// Input channel (item_valid, item_stall, item): one event per transfer, a
// CPU-cycle tick, a register write, a status read or an IRQ line sample.
// Output channel (result_valid, result_stall, result): exactly one result
// per event, in order: status byte, IRQ line and the quarter/half clocks.
// Path: an item taken into the input register is processed into the result
// register once the result stage is free, and its result transfers out from
// the result register.
// Throughput: one item per cycle while no result is stalled; all state
// updates for an item are done in a single pass between the input register
// and the result register, and the sequencer and counter state loop back.
// Reset: the sequencer starts in the put half, 4-step mode, counter zero,
// no restart pending, interrupts clear, all length counters zero and
// all channels disabled. Both pipeline stages come up empty.
// Stall: while result_stall holds a result, the input register keeps its
// item and item_stall rises once it is full; nothing is lost or repeated.
module apu_frame_and_length_unit
    import apu_fal_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  apu_item_t   item,
    output logic        result_valid,
    input  logic        result_stall,
    output apu_result_t result
);

    logic              in_vld_reg, in_vld_next;
    apu_item_t         in_reg;
    logic              res_vld_reg, res_vld_next;
    apu_result_t       res_reg;
    apu_result_t       res_next;
    logic              advance;
    logic              take_in;
    seq_len_t          seq_to_len;
    seq_res_t          seq_res;
    logic [NUM_CH-1:0] len_nonzero;
    logic              half_out;
    logic              status_spare;

    // Handshake: advance the input stage when the result stage frees up
    assign advance      = in_vld_reg && (!res_vld_reg || !result_stall);
    assign item_stall   = in_vld_reg && !advance;
    assign take_in      = item_valid && !item_stall;
    assign result_valid = res_vld_reg;
    assign result       = res_reg;

    apu_fal_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .item   (in_reg),
        .to_len (seq_to_len),
        .res    (seq_res)
    );

    apu_fal_len u_len (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .item     (in_reg),
        .from_seq (seq_to_len),
        .nonzero  (len_nonzero)
    );

    // Assemble the result of the item in the input register
    always_comb
    begin
        res_next.read_data = 8'd0;
        if (in_reg.kind == KIND_READ)
            res_next.read_data = {1'b0, seq_res.irq_flag, in_reg.open_bus_bit5, 1'b0,
                                  len_nonzero};
        res_next.irq_out       = seq_res.irq_out;
        res_next.quarter_clock = seq_res.quarter_clock;
        res_next.half_clock    = seq_res.half_clock;
    end

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (take_in)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;
        res_vld_next = res_vld_reg;
        if (advance)
            res_vld_next = 1'b1;
        else if (result_valid && !result_stall)
            res_vld_next = 1'b0;
    end

    // Hold the stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            res_vld_reg <= res_vld_next;
        end
    end

    // Load payload registers on transfer
    always_ff @(posedge clk)
    begin
        if (take_in)
            in_reg <= item;
        if (advance)
            res_reg <= res_next;
    end

    // Result bits that the checks below look at
    assign half_out     = result_valid && result.half_clock;
    assign status_spare = result.read_data[7] | result.read_data[4];

`include "apu_frame_and_length_unit_assert.svh"

    `APU_ASSERT_IMPLIES(a_half_has_quarter, half_out, result.quarter_clock, "lone half clock")
    `APU_ASSERT_IMPLIES(a_status_unused_bits, result_valid, !status_spare, "unused status bits set")
    `APU_ASSERT_IMPLIES(a_empty_never_stalls, !in_vld_reg, !item_stall, "stall while empty")

endmodule

// File: tb/tb_top.sv
`default_nettype none

module tb_top;
    import apu_fal_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Register offsets used by the bench besides status and frame
    localparam logic [4:0] REG_SQ1_VOL   = 5'h00;
    localparam logic [4:0] REG_SQ1_LEN   = 5'h03;
    localparam logic [4:0] REG_SQ2_VOL   = 5'h04;
    localparam logic [4:0] REG_SQ2_LEN   = 5'h07;
    localparam logic [4:0] REG_TRI_LIN   = 5'h08;
    localparam logic [4:0] REG_TRI_LEN   = 5'h0B;
    localparam logic [4:0] REG_NOISE_VOL = 5'h0C;
    localparam logic [4:0] REG_NOISE_LEN = 5'h0F;
    localparam logic [4:0] REG_DMC_FREQ  = 5'h10;
    localparam logic [4:0] REG_OAM_DMA   = 5'h14;
    localparam logic [4:0] REG_JOY1      = 5'h16;
    localparam logic [4:0] REG_LAST      = 5'h17;

    // Status byte bit positions
    localparam int STAT_OPEN_BUS  = 5;
    localparam int STAT_FRAME_IRQ = 6;

    localparam int NUM_PHASES   = 6;
    localparam int EV_PER_PHASE = 60;
    localparam int QUIET_TAIL   = 100;
    localparam int IDLE_WINDOW  = 150;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 100000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    apu_item_t   item;
    logic        result_valid;
    logic        result_stall;
    apu_result_t result;

    apu_item_t   pending_items[$];
    apu_result_t expected_results[$];

    int unsigned cycle_count   = 0;
    int unsigned items_sent    = 0;
    int unsigned items_taken   = 0;
    int unsigned results_seen  = 0;
    int unsigned error_count   = 0;
    int unsigned reads_taken   = 0;
    int unsigned writes_taken  = 0;
    int unsigned samples_taken = 0;
    int unsigned quarters_seen = 0;
    int unsigned halves_seen   = 0;
    int unsigned irq_high_seen = 0;
    logic        in_taken      = 1'b0;
    int          hold_left     = 0;
    logic        hold_done     = 1'b0;
    int          src_gap       = 0;
    int          snk_gap       = 0;

    // Sequencer and length counter state of the predictor
    logic        seq_put       = 1'b1;
    logic        seq_five      = 1'b0;
    logic        seq_inhibit   = 1'b0;
    logic [7:0]  seq_restart   = DELAY_IDLE;
    logic [15:0] seq_count     = '0;
    logic        seq_qpend     = 1'b0;
    logic        seq_hpend     = 1'b0;
    logic        pr_irq_flag   = 1'b0;
    logic        pr_irq_clr    = 1'b0;
    logic        pr_irq_wire   = 1'b0;
    logic [3:0]  ch_en         = '0;
    logic [3:0]  len_halt      = '0;
    logic [3:0]  len_reload    = '0;
    logic [3:0]  halt_src      = '0;
    logic [7:0]  len_cnt [NUM_CH];
    logic [7:0]  len_val [NUM_CH];

    apu_frame_and_length_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Advance the sequencer and length counters by one event
    function automatic apu_result_t predict_event(apu_item_t ev);
        apu_result_t r;
        logic [7:0]  sb;
        int          c;
        int          ch;
        r = '0;
        if (ev.kind == KIND_TICK) begin
            // Clear the frame interrupt on the put half after a status read
            if (seq_put && pr_irq_clr) begin
                pr_irq_clr  = 1'b0;
                pr_irq_flag = 1'b0;
                pr_irq_wire = 1'b0;
            end
            if (!seq_restart[7]) begin
                seq_restart = seq_restart - 8'd1;
                if (seq_restart[7])
                    seq_count = '0;
            end
            seq_count = seq_count + 16'd1;
            if (seq_count == STEP_Q1 || seq_count == STEP_Q3) begin
                seq_qpend = 1'b1;
            end
            else if (seq_count == STEP_Q2) begin
                seq_qpend = 1'b1;
                seq_hpend = 1'b1;
            end
            else if (seq_five) begin
                if (seq_count == STEP5_HALF) begin
                    seq_qpend = 1'b1;
                    seq_hpend = 1'b1;
                end
                else if (seq_count == STEP5_END) begin
                    seq_count = '0;
                end
            end
            else if (seq_count == STEP4_IRQ) begin
                pr_irq_flag = 1'b1;
            end
            else if (seq_count == STEP4_HALF) begin
                seq_qpend   = 1'b1;
                seq_hpend   = 1'b1;
                pr_irq_flag = 1'b1;
                if (!seq_inhibit)
                    pr_irq_wire = 1'b1;
            end
            else if (seq_count == STEP4_END) begin
                pr_irq_flag = !seq_inhibit;
                if (!seq_inhibit)
                    pr_irq_wire = 1'b1;
                seq_count = '0;
            end
            r.quarter_clock = seq_qpend;
            r.half_clock    = seq_hpend;
            seq_qpend       = 1'b0;
            // Clock the length counters on a half frame or a pending reload
            if (seq_hpend || (|len_reload)) begin
                for (c = 0; c < NUM_CH; c++) begin
                    if (seq_hpend) begin
                        if (len_reload[c] && len_cnt[c] == 8'd0)
                            len_cnt[c] = len_val[c];
                        else
                            len_reload[c] = 1'b0;
                        if (!ch_en[c])
                            len_cnt[c] = 8'd0;
                        if (len_cnt[c] != 8'd0 && !len_halt[c] && !len_reload[c])
                            len_cnt[c] = len_cnt[c] - 8'd1;
                    end
                    else begin
                        if (len_reload[c])
                            len_cnt[c] = len_val[c];
                        len_reload[c] = 1'b0;
                    end
                end
            end
            seq_hpend = 1'b0;
            len_halt  = halt_src;
            seq_put   = !seq_put;
        end
        else if (ev.kind == KIND_WRITE) begin
            case (ev.reg_addr)
                REG_SQ1_VOL, REG_SQ2_VOL, REG_NOISE_VOL:
                    halt_src[ev.reg_addr[3:2]] = ev.write_data[5];
                REG_TRI_LIN:
                    halt_src[ev.reg_addr[3:2]] = ev.write_data[7];
                REG_SQ1_LEN, REG_SQ2_LEN, REG_TRI_LEN, REG_NOISE_LEN: begin
                    ch = ev.reg_addr[3:2];
                    if (ch_en[ch]) begin
                        len_val[ch]    = LEN_TABLE[ev.write_data[7:3]];
                        len_reload[ch] = 1'b1;
                    end
                end
                REG_STATUS: begin
                    for (c = 0; c < NUM_CH; c++) begin
                        ch_en[c] = ev.write_data[c];
                        if (!ev.write_data[c])
                            len_cnt[c] = 8'd0;
                    end
                end
                REG_FRAME: begin
                    seq_five    = ev.write_data[7];
                    seq_inhibit = ev.write_data[6];
                    if (seq_five) begin
                        seq_hpend = 1'b1;
                        seq_qpend = 1'b1;
                    end
                    if (seq_inhibit) begin
                        pr_irq_flag = 1'b0;
                        pr_irq_wire = 1'b0;
                    end
                    seq_restart = seq_put ? DELAY_PUT : DELAY_GET;
                end
                default: ;
            endcase
        end
        else if (ev.kind == KIND_READ) begin
            sb = '0;
            sb[STAT_OPEN_BUS]  = ev.open_bus_bit5;
            sb[STAT_FRAME_IRQ] = pr_irq_flag;
            for (c = 0; c < NUM_CH; c++)
                sb[c] = (len_cnt[c] != 8'd0);
            pr_irq_clr  = 1'b1;
            r.read_data = sb;
        end
        else begin
            // Sample reports the line as it was, then latches a raised flag
            r.irq_out = pr_irq_wire | ev.cart_irq;
            if (pr_irq_flag && !seq_inhibit)
                pr_irq_wire = 1'b1;
            return r;
        end
        r.irq_out = pr_irq_wire | ev.cart_irq;
        return r;
    endfunction

    task automatic add_item(input logic [1:0] k, input logic [4:0] a, input logic [7:0] d);
        apu_item_t ev;
        ev.kind          = k;
        ev.reg_addr      = a;
        ev.write_data    = d;
        ev.open_bus_bit5 = 1'($urandom_range(0, 1));
        ev.cart_irq      = 1'($urandom_range(0, 1));
        pending_items.push_back(ev);
    endtask

    task automatic log_error(input string what);
        error_count++;
        if (error_count <= 10)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Offer queued items; hold the payload until the transfer completes
    always @(negedge clk)
    begin : driver
        logic idle_ok;
        if (rst_n && (!item_valid || in_taken)) begin
            idle_ok = pending_items.size() >= QUIET_TAIL && hold_left == 0
                      && ((items_sent / IDLE_WINDOW) % 3) != 2;
            if (src_gap == 0 && idle_ok && $urandom_range(0, 23) == 0)
                src_gap = $urandom_range(1, 16);
            if (src_gap != 0 || pending_items.size() == 0) begin
                if (src_gap != 0)
                    src_gap--;
                item_valid <= 1'b0;
            end
            else begin
                item       <= pending_items.pop_front();
                item_valid <= 1'b1;
                items_sent++;
            end
        end
    end

    // Stall the result channel in random bursts and during the long hold
    always @(negedge clk)
    begin : receiver
        logic busy;
        busy = 1'b0;
        if (snk_gap != 0) begin
            busy = 1'b1;
            snk_gap--;
        end
        else if (pending_items.size() >= QUIET_TAIL
                 && ((results_seen / IDLE_WINDOW) % 3) != 1
                 && $urandom_range(0, 23) == 0) begin
            busy    = 1'b1;
            snk_gap = $urandom_range(0, 15);
        end
        result_stall <= busy || (hold_left != 0);
    end

    // Count down the long hold-off once, well into the run
    always @(negedge clk)
    begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && items_taken >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Predict on each input transfer, check each result transfer
    always @(posedge clk)
    begin : monitor
        apu_result_t want;
        if (rst_n) begin
            in_taken = item_valid && !item_stall;
            if (in_taken) begin
                expected_results.push_back(predict_event(item));
                items_taken++;
                if (item.kind == KIND_READ)
                    reads_taken++;
                else if (item.kind == KIND_WRITE)
                    writes_taken++;
                else if (item.kind == KIND_SAMPLE)
                    samples_taken++;
            end
            if (result_valid && !result_stall) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    log_error($sformatf("result %0d arrived with nothing expected (%h)",
                                        results_seen, result));
                end
                else begin
                    want = expected_results.pop_front();
                    if (result.read_data !== want.read_data)
                        log_error($sformatf("result %0d read_data exp %h got %h",
                                            results_seen, want.read_data, result.read_data));
                    if (result.irq_out !== want.irq_out)
                        log_error($sformatf("result %0d irq_out exp %b got %b",
                                            results_seen, want.irq_out, result.irq_out));
                    if (result.quarter_clock !== want.quarter_clock)
                        log_error($sformatf("result %0d quarter_clock exp %b got %b",
                                            results_seen, want.quarter_clock,
                                            result.quarter_clock));
                    if (result.half_clock !== want.half_clock)
                        log_error($sformatf("result %0d half_clock exp %b got %b",
                                            results_seen, want.half_clock, result.half_clock));
                    quarters_seen += want.quarter_clock;
                    halves_seen   += want.half_clock;
                    irq_high_seen += want.irq_out;
                end
            end
        end
    end

    // Abort a run that stops making progress
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timed out after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("** apu_frame_and_length_unit: FAILED **");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [1:0] mode_sel [NUM_PHASES];
        int         p;
        int         e;
        int         n;
        int         r;
        int         run;
        logic [4:0] a;
        logic [7:0] d;

        mode_sel = '{2'b00, 2'b10, 2'b01, 2'b11, 2'b00, 2'b10};
        for (n = 0; n < NUM_CH; n++) begin
            len_cnt[n] = 8'd0;
            len_val[n] = 8'd0;
        end
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_stall = 1'b0;

        // Directed: table extremes, halt sources, ignored offsets, restarts
        add_item(KIND_READ,   5'h00,         8'h00);
        add_item(KIND_SAMPLE, 5'h1F - 5'h08, 8'hFF);
        add_item(KIND_WRITE,  REG_STATUS,    8'hFF);
        add_item(KIND_WRITE,  REG_SQ1_LEN,   8'hF8);
        add_item(KIND_WRITE,  REG_SQ2_LEN,   8'h08);
        add_item(KIND_WRITE,  REG_TRI_LEN,   8'h00);
        add_item(KIND_WRITE,  REG_NOISE_LEN, 8'hFF);
        add_item(KIND_TICK,   5'h00,         8'h00);
        add_item(KIND_READ,   5'h00,         8'h00);
        add_item(KIND_WRITE,  REG_SQ1_VOL,   8'h20);
        add_item(KIND_WRITE,  REG_TRI_LIN,   8'h80);
        add_item(KIND_WRITE,  REG_NOISE_VOL, 8'hDF);
        add_item(KIND_WRITE,  REG_DMC_FREQ,  8'hFF);
        // Reload while the count is nonzero, then an immediate half clock
        add_item(KIND_WRITE,  REG_SQ1_LEN,   8'h18);
        add_item(KIND_WRITE,  REG_FRAME,     8'h80);
        add_item(KIND_TICK,   5'h00,         8'h00);
        // Load into a disabled channel
        add_item(KIND_WRITE,  REG_STATUS,    8'h05);
        add_item(KIND_WRITE,  REG_SQ2_LEN,   8'hF8);
        add_item(KIND_TICK,   5'h00,         8'h00);
        // Restart again inside the delay window
        add_item(KIND_WRITE,  REG_FRAME,     8'h40);
        add_item(KIND_TICK,   5'h00,         8'h00);
        add_item(KIND_READ,   5'h00,         8'h00);
        add_item(KIND_SAMPLE, 5'h00,         8'h00);
        add_item(KIND_WRITE,  REG_JOY1,      8'hAA);
        add_item(KIND_WRITE,  REG_OAM_DMA,   8'h55);

        // Random phases: a mode write, then a mix of events and short tick runs
        for (p = 0; p < NUM_PHASES; p++) begin
            add_item(KIND_WRITE, REG_FRAME, {mode_sel[p], 6'($urandom_range(0, 63))});
            if ($urandom_range(0, 2) == 0) begin
                add_item(KIND_TICK, 5'($urandom_range(0, 23)), 8'($urandom_range(0, 255)));
                add_item(KIND_WRITE, REG_FRAME, {mode_sel[p], 6'($urandom_range(0, 63))});
            end
            for (e = 0; e < EV_PER_PHASE; e++) begin
                run = $urandom_range(0, 2);
                for (n = 0; n < run; n++)
                    add_item(KIND_TICK, 5'($urandom_range(0, 23)),
                             8'($urandom_range(0, 255)));
                r = $urandom_range(0, 99);
                d = 8'($urandom_range(0, 255));
                if (r < 50) begin
                    r = $urandom_range(0, 99);
                    if (r < 20) begin
                        a = REG_STATUS;
                        if ($urandom_range(0, 1) == 0)
                            d = d | 8'h0F;
                    end
                    else if (r < 55) begin
                        a = {3'($urandom_range(0, 3)), 2'b11};
                    end
                    else if (r < 75) begin
                        a = {3'($urandom_range(0, 3)), 2'b00};
                    end
                    else begin
                        a = 5'($urandom_range(0, REG_LAST));
                        // keep the phase's mode on a frame restart
                        if (a == REG_FRAME)
                            d = {mode_sel[p], d[5:0]};
                    end
                    add_item(KIND_WRITE, a, d);
                end
                else if (r < 75) begin
                    add_item(KIND_READ, 5'($urandom_range(0, 23)), d);
                end
                else if (r < 92) begin
                    add_item(KIND_SAMPLE, 5'($urandom_range(0, 23)), d);
                end
                else begin
                    add_item(KIND_TICK, 5'($urandom_range(0, 23)), d);
                end
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain: all items transferred, all results back, then a short tail
        while (pending_items.size() != 0 || item_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d events: %0d writes, %0d status reads, %0d irq samples, rest ticks",
                 items_taken, writes_taken, reads_taken, samples_taken);
        $display("saw %0d quarter-frame and %0d half-frame clocks, %0d results with irq high",
                 quarters_seen, halves_seen, irq_high_seen);
        if (error_count == 0)
            $display("** apu_frame_and_length_unit: PASSED **");
        else
            $display("** apu_frame_and_length_unit: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
+incdir+hdl
hdl/apu_fal_pkg.sv
hdl/apu_fal_seq.sv
hdl/apu_fal_len.sv
hdl/apu_frame_and_length_unit.sv
tb/tb_top.sv
